// ===== rtl/set_median_mode_mean_top_macros.svh =====
// Assertion macros shared by the statistics block's RTL files.
`ifndef SET_MEDIAN_MODE_MEAN_TOP_MACROS_SVH
`define SET_MEDIAN_MODE_MEAN_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smm_pkg.sv =====
// Package with the field widths, default sizes and request types of the statistics block.
`default_nettype none

package smm_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int VALUE_MAX_DEF = 100;
    localparam int MEAN_FRAC     = 8;

    localparam int SAMPLE_W = 7;
    localparam int MEDIAN_W = 8;
    localparam int MODE_W   = 7;
    localparam int MEAN_W   = 15;
    localparam int COUNT_W  = 11;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                last_item;
    } t_in_item;

    typedef struct packed {
        logic [MEDIAN_W-1:0] median_doubled;
        logic [MODE_W-1:0]   mode_value;
        logic [MEAN_W-1:0]   mean_q8;
        logic [COUNT_W-1:0]  item_count;
        logic                overflow_flag;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/smm_chan_if.sv =====
// Valid/ready channel interface carrying one request payload.
`default_nettype none

interface smm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/set_median_mode_mean_top.sv =====
// Top level of the mean, median and mode statistics block.
// Usage: values of a data set arrive on i_in_ch, one request per value, the final
// one marked with last_item. Each value above VALUE_MAX is saturated to it.
// While a set is loading, i_in_ch.ready stays high and one value is taken every
// cycle; a read-modify-write of the histogram memory with one-entry forwarding
// sustains that rate. Values beyond MAX_ITEMS are dropped and flagged.
// After the marked value the block walks all VALUE_MAX + 1 histogram bins, one
// per cycle through the memory read port, then runs a bit-serial divider for the
// mean (one bit per cycle, sum width + 8 bits). The result request appears on
// o_out_ch once the walk and the division are done, and input is paused until
// the result is loaded. The result sits in an output register until taken,
// and loading of the next set may proceed meanwhile; a finished result waits
// only if the previous one has not been taken yet.
// After reset, a clearing pass writes zero to every bin, during which
// i_in_ch.ready is low. The histogram is cleared again during each walk, so
// no further clearing pass is needed.
`default_nettype none
`include "set_median_mode_mean_top_macros.svh"

module set_median_mode_mean_top #(
    parameter int MAX_ITEMS = smm_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_MAX = smm_pkg::VALUE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smm_chan_if.sink    i_in_ch,
    smm_chan_if.source  o_out_ch
);

    import smm_pkg::*;

    localparam int NBINS  = VALUE_MAX + 1;
    localparam int ADDR_W = $clog2(NBINS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W  = $clog2(MAX_ITEMS * VALUE_MAX + 1);
    localparam int QUO_W  = SUM_W + MEAN_FRAC;
    localparam int MED_W  = ADDR_W + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SETTLE = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_HOLD   = 3'd5;

    // Histogram memory and its read register.
    logic [CNT_W-1:0]  mem [NBINS];
    logic [CNT_W-1:0]  r_rd_data;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_issue_done, n_issue_done;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_dropped, n_dropped;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out;

    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_fwd_hit;
    logic [CNT_W-1:0]  r_fwd_val;

    logic              r_wv;
    logic [ADDR_W-1:0] r_wa;
    logic [CNT_W-1:0]  r_cum;
    logic [CNT_W-1:0]  r_best;
    logic [ADDR_W-1:0] r_mode;
    logic [ADDR_W-1:0] r_lo;
    logic [ADDR_W-1:0] r_hi;
    logic              r_found_lo;
    logic              r_found_hi;

    logic [ADDR_W-1:0] in_value;
    logic              accept;
    logic              take;
    logic              slot_free;
    logic              load_out;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [CNT_W-1:0]  inc;
    logic [CNT_W-1:0]  cum_n;
    logic [CNT_W-1:0]  k_hi;
    logic [CNT_W-1:0]  k_lo;
    logic [MED_W-1:0]  median;

    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CNT_W-1:0]  mem_wd;

    always_comb begin
        if (int'(i_in_ch.data.sample_value) > VALUE_MAX) begin
            in_value = ADDR_W'(VALUE_MAX);
        end else begin
            in_value = ADDR_W'(i_in_ch.data.sample_value);
        end
    end

    assign i_in_ch.ready = (r_state == ST_LOAD);
    assign accept        = i_in_ch.valid && i_in_ch.ready;
    assign take          = accept && (r_count < CNT_W'(MAX_ITEMS));
    assign slot_free     = !r_out_valid || o_out_ch.ready;

    // A bin written back this cycle is forwarded to a request for the same bin.
    assign inc = (r_fwd_hit ? r_fwd_val : r_rd_data) + 1'b1;

    assign k_hi   = r_count >> 1;
    assign k_lo   = r_count[0] ? k_hi : k_hi - 1'b1;
    assign cum_n  = r_cum + r_rd_data;
    assign median = MED_W'(r_lo) + MED_W'(r_hi);

    always_comb begin
        mem_re = take || (r_state == ST_WALK && !r_issue_done);
        mem_ra = (r_state == ST_WALK) ? r_addr : in_value;
        mem_we = r_s1_valid || r_wv || (r_state == ST_CLEAR);
        if (r_s1_valid) begin
            mem_wa = r_s1_addr;
        end else if (r_wv) begin
            mem_wa = r_wa;
        end else begin
            mem_wa = r_addr;
        end
        mem_wd = r_s1_valid ? inc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_count      = r_count;
        n_sum        = r_sum;
        n_dropped    = r_dropped;
        n_out_valid  = r_out_valid && !o_out_ch.ready;
        load_out     = 1'b0;
        div_start    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == ADDR_W'(VALUE_MAX)) begin
                    n_state = ST_LOAD;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_LOAD: begin
                if (accept) begin
                    if (take) begin
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + SUM_W'(in_value);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_ch.data.last_item) begin
                        n_state = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                // The last histogram write lands here, before the walk reads.
                n_state      = ST_WALK;
                n_addr       = '0;
                n_issue_done = 1'b0;
            end
            ST_WALK: begin
                if (!r_issue_done) begin
                    if (r_addr == ADDR_W'(VALUE_MAX)) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_wv && r_wa == ADDR_W'(VALUE_MAX)) begin
                    n_state   = ST_DIV;
                    div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (slot_free) begin
                        load_out = 1'b1;
                        n_state  = ST_LOAD;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
            n_count     = '0;
            n_sum       = '0;
            n_dropped   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_dropped    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_wv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_count      <= n_count;
            r_sum        <= n_sum;
            r_dropped    <= n_dropped;
            r_out_valid  <= n_out_valid;
            r_s1_valid   <= take;
            r_wv         <= (r_state == ST_WALK) && !r_issue_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= in_value;
        r_fwd_hit <= r_s1_valid && (r_s1_addr == in_value);
        r_fwd_val <= inc;
        r_wa      <= r_addr;
        if (r_state == ST_SETTLE) begin
            r_cum      <= '0;
            r_best     <= '0;
            r_mode     <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_found_lo <= 1'b0;
            r_found_hi <= 1'b0;
        end else if (r_wv) begin
            r_cum <= cum_n;
            // Strictly greater keeps the smallest value among equal counts.
            if (r_rd_data > r_best) begin
                r_best <= r_rd_data;
                r_mode <= r_wa;
            end
            if (!r_found_lo && cum_n > k_lo) begin
                r_lo       <= r_wa;
                r_found_lo <= 1'b1;
            end
            if (!r_found_hi && cum_n > k_hi) begin
                r_hi       <= r_wa;
                r_found_hi <= 1'b1;
            end
        end
        if (load_out) begin
            r_out.median_doubled <= MEDIAN_W'(median);
            r_out.mode_value     <= MODE_W'(r_mode);
            r_out.mean_q8        <= MEAN_W'(div_quo);
            r_out.item_count     <= COUNT_W'(r_count);
            r_out.overflow_flag  <= r_dropped;
        end
    end

    smm_div #(
        .DIVIDEND_W (QUO_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum, {MEAN_FRAC{1'b0}}}),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    `SMM_ASSERT_IMPL(a_walk_flushed, i_clk, i_rst_n, (r_state == ST_WALK), !r_s1_valid,
                     "histogram update pending during walk")
    `SMM_ASSERT_IMPL(a_median_found, i_clk, i_rst_n, (r_state == ST_DIV),
                     (r_found_lo && r_found_hi), "median ranks not reached in walk")
    `SMM_ASSERT_IMPL(a_mode_found, i_clk, i_rst_n, (r_state == ST_DIV), (r_best != '0),
                     "no populated bin found in walk")
    `SMM_ASSERT_IMPL(a_median_order, i_clk, i_rst_n, (r_state == ST_DIV), (r_lo <= r_hi),
                     "lower middle value above upper one")

endmodule

`default_nettype wire

// ===== rtl/smm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
`include "set_median_mode_mean_top_macros.svh"

module smm_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // The partial remainder stays below the divisor, so the shifted value fits.
    always_comb begin
        rem_sh = {r_rem[DIVISOR_W-1:0], r_quo[DIVIDEND_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `SMM_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider started while busy")
    `SMM_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, (r_busy && r_cnt == CNT_W'(1)), r_done, "missing done after last step")
    `SMM_ASSERT_IMPL(a_fall_done, i_clk, i_rst_n, $fell(r_busy), r_done, "divider went idle without done")

endmodule

`default_nettype wire

// ===== dv/set_median_mode_mean_top_test.sv =====
// Self-checking testbench for the mean, median and mode statistics block.
`default_nettype none

module set_median_mode_mean_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import smm_pkg::*;

    localparam int NBINS = VALUE_MAX_DEF + 1;
    localparam int RESULT_WAIT = 160;

    logic i_clk;
    logic i_rst_n;

    smm_chan_if #(.T(t_in_item))  in_ch ();
    smm_chan_if #(.T(t_out_item)) out_ch ();

    set_median_mode_mean_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // Running statistics of the set being loaded, as the block should hold them.
    bit [COUNT_W-1:0] bin_count [NBINS];
    bit [16:0]        set_sum;
    bit [COUNT_W-1:0] set_count;
    bit               set_dropped;
    t_out_item        stats_due [$];

    int mismatches;
    int samples_sent;
    int sets_sent;
    int results_seen;
    int rx_hold_left;
    bit no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("set_median_mode_mean_top: mismatch");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 30) begin
            $display("ERROR at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned value_at_rank(int unsigned k);
        int unsigned cum;
        cum = 0;
        for (int v = 0; v < NBINS; v++) begin
            cum += bin_count[v];
            if (cum > k) begin
                return v;
            end
        end
        return VALUE_MAX_DEF;
    endfunction

    // Folds one accepted sample into the set; the marked one closes the set.
    function automatic void stats_fold(bit [SAMPLE_W-1:0] raw, bit last);
        int unsigned      v;
        int unsigned      best;
        int unsigned      n;
        longint unsigned  scaled;
        t_out_item        res;
        v = (raw > VALUE_MAX_DEF) ? VALUE_MAX_DEF : raw;
        if (set_count < MAX_ITEMS_DEF) begin
            bin_count[v]++;
            set_sum += 17'(v);
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) begin
            return;
        end
        n = set_count;
        res = '0;
        if (n[0]) begin
            res.median_doubled = MEDIAN_W'(2 * value_at_rank(n / 2));
        end else begin
            res.median_doubled = MEDIAN_W'(value_at_rank(n / 2) + value_at_rank(n / 2 - 1));
        end
        best = 0;
        for (int b = 0; b < NBINS; b++) begin
            if (bin_count[b] > best) begin
                best = bin_count[b];
                res.mode_value = MODE_W'(b);
            end
        end
        scaled = set_sum;
        scaled = (scaled << MEAN_FRAC) / n;
        res.mean_q8 = scaled[MEAN_W-1:0];
        res.item_count = set_count;
        res.overflow_flag = set_dropped;
        stats_due.push_back(res);
        for (int b = 0; b < NBINS; b++) begin
            bin_count[b] = '0;
        end
        set_sum = '0;
        set_count = '0;
        set_dropped = 1'b0;
    endfunction

    // Offers one sample, waits for the handshake, then idles for a random gap.
    task automatic send_sample(bit [SAMPLE_W-1:0] value, bit last);
        t_in_item req;
        int       gap;
        req.sample_value = value;
        req.last_item = last;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= req;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        stats_fold(value, last);
        samples_sent++;
        if (last) begin
            sets_sent++;
        end
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            // The payload is junk while valid is low.
            in_ch.data <= t_in_item'((SAMPLE_W + 1)'($urandom_range(0, 255)));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Withdraws the offer, then waits until every finished set has been checked.
    task automatic wait_sets_done();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (stats_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_single_value_sets();
        send_sample(7'd0, 1'b1);
        send_sample(7'd100, 1'b1);
        send_sample(7'd127, 1'b1);
        send_sample(7'd64, 1'b1);
        send_sample(7'd101, 1'b1);
        wait_sets_done();
    endtask

    task automatic test_median_and_mode();
        // Even count: the doubled median is the sum of the two middle values.
        send_sample(7'd3, 1'b0);
        send_sample(7'd8, 1'b1);
        // Tied frequencies: the smallest value wins the mode.
        send_sample(7'd5, 1'b0);
        send_sample(7'd5, 1'b0);
        send_sample(7'd2, 1'b0);
        send_sample(7'd2, 1'b0);
        send_sample(7'd9, 1'b1);
        send_sample(7'd100, 1'b0);
        send_sample(7'd0, 1'b0);
        send_sample(7'd127, 1'b0);
        send_sample(7'd0, 1'b1);
        send_sample(7'd7, 1'b0);
        send_sample(7'd1, 1'b0);
        send_sample(7'd4, 1'b1);
        wait_sets_done();
    endtask

    task automatic test_output_backpressure();
        // The receiver holds off while several sets go in, so the block must
        // park finished results and then stall its input.
        rx_hold_left = 600;
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 6; i++) begin
                send_sample(SAMPLE_W'($urandom_range(0, 100)), i == 5);
            end
        end
        wait_sets_done();
    endtask

    task automatic test_random_sets();
        int           size;
        int           flavour;
        int           drawn;
        bit [SAMPLE_W-1:0] pool [3];
        bit [SAMPLE_W-1:0] value;
        drawn = 0;
        while (drawn < 500) begin
            size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 80);
            flavour = $urandom_range(0, 3);
            for (int p = 0; p < 3; p++) begin
                pool[p] = SAMPLE_W'($urandom_range(0, 100));
            end
            no_idle = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < size; i++) begin
                case (flavour)
                    0: begin
                        value = SAMPLE_W'($urandom_range(0, 100));
                    end
                    1: begin
                        value = pool[$urandom_range(0, 2)];
                    end
                    2: begin
                        value = ($urandom_range(0, 2) == 0) ? 7'd0 :
                                ($urandom_range(0, 1) == 0) ? 7'd100 : 7'd127;
                    end
                    default: begin
                        value = SAMPLE_W'($urandom_range(0, 127));
                    end
                endcase
                send_sample(value, i == size - 1);
            end
            drawn += size;
            if ($urandom_range(0, 19) == 0) begin
                wait_sets_done();
            end
        end
        no_idle = 1'b0;
    endtask

    // Result receiver: random stalls, plus the long hold-off when asked for.
    initial begin : result_sink
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = no_idle ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results_seen++;
            if (stats_due.size() == 0) begin
                report_mismatch("result with no set pending", got.item_count, 0);
            end else begin
                want = stats_due.pop_front();
                if (got.median_doubled !== want.median_doubled) begin
                    report_mismatch("median_doubled", got.median_doubled, want.median_doubled);
                end
                if (got.mode_value !== want.mode_value) begin
                    report_mismatch("mode_value", got.mode_value, want.mode_value);
                end
                if (got.mean_q8 !== want.mean_q8) begin
                    report_mismatch("mean_q8", got.mean_q8, want.mean_q8);
                end
                if (got.item_count !== want.item_count) begin
                    report_mismatch("item_count", got.item_count, want.item_count);
                end
                if (got.overflow_flag !== want.overflow_flag) begin
                    report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_value_sets();
        test_median_and_mode();
        test_output_backpressure();
        test_random_sets();

        wait_sets_done();
        repeat (RESULT_WAIT) @(posedge i_clk);

        $display("Sent %0d samples in %0d sets and checked %0d results.",
                 samples_sent, sets_sent, results_seen);
        $display("%s", {"Covered single, tied and even sets, saturated samples, ",
                        "a long result hold-off and random gaps on both channels."});
        if (mismatches == 0) begin
            $display("set_median_mode_mean_top: match");
        end else begin
            $display("set_median_mode_mean_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_chan_if.sv
rtl/smm_div.sv
rtl/set_median_mode_mean_top.sv
dv/set_median_mode_mean_top_test.sv
